### design/ofbm_pkg.sv
package ofbm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int STEPS     = FRAC_BITS + 1;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int R_W       = 96;
  localparam int P_W       = 80;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic [2:0]         degenerate_rows;
  } out_word_t;

  // One row to normalize: sum of squares, per-entry squares, entry signs.
  typedef struct packed {
    logic [63:0]      s;
    logic [2:0][63:0] t;
    logic [2:0]       neg;
  } row_t;

endpackage

### design/ofbm_in_if.sv
interface ofbm_in_if;
  logic               valid;
  logic               ready;
  ofbm_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/ofbm_out_if.sv
interface ofbm_out_if;
  logic                valid;
  logic                ready;
  ofbm_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/ofbm_front.sv
module ofbm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  ofbm_pkg::in_word_t word,
  output logic               out_vld,
  output ofbm_pkg::row_t     row_p,
  output ofbm_pkg::row_t     row_v,
  output ofbm_pkg::row_t     row_x
);

  logic [3:0] vld;

  // stage 1: squares and cross partial products
  logic [2:0][31:0]        pp, vv;
  logic signed [2:0][31:0] xa, xb;
  logic [2:0]              np, nv;
  // stage 2: cross differences, position and velocity rows
  logic [2:0][31:0]        mx;
  logic [2:0]              nx;
  ofbm_pkg::row_t          rp2, rv2;
  // stage 3: cross squares
  logic [2:0][63:0]        xx;
  logic [2:0]              nx3;
  ofbm_pkg::row_t          rp3, rv3;

  logic signed [15:0]      p [3];
  logic signed [15:0]      v [3];
  logic signed [32:0]      xd [3];

  always_comb begin
    p[0] = word.pos_x;
    p[1] = word.pos_y;
    p[2] = word.pos_z;
    v[0] = word.vel_x;
    v[1] = word.vel_y;
    v[2] = word.vel_z;
    for (int i = 0; i < 3; i++) begin
      xd[i] = {xa[i][31], xa[i]} - {xb[i][31], xb[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pp[i] <= 32'(p[i] * p[i]);
        vv[i] <= 32'(v[i] * v[i]);
        np[i] <= p[i][15];
        nv[i] <= v[i][15];
      end
      xa[0] <= p[1] * v[2];
      xb[0] <= p[2] * v[1];
      xa[1] <= p[2] * v[0];
      xb[1] <= p[0] * v[2];
      xa[2] <= p[0] * v[1];
      xb[2] <= p[1] * v[0];

      for (int i = 0; i < 3; i++) begin
        mx[i]       <= xd[i][32] ? 32'(-xd[i]) : xd[i][31:0];
        nx[i]       <= xd[i][32];
        rp2.t[i]    <= {32'd0, pp[i]};
        rv2.t[i]    <= {32'd0, vv[i]};
      end
      rp2.s   <= 64'({2'd0, pp[0]} + {2'd0, pp[1]} + {2'd0, pp[2]});
      rv2.s   <= 64'({2'd0, vv[0]} + {2'd0, vv[1]} + {2'd0, vv[2]});
      rp2.neg <= np;
      rv2.neg <= nv;

      for (int i = 0; i < 3; i++) begin
        xx[i] <= 64'(mx[i] * mx[i]);
      end
      nx3 <= nx;
      rp3 <= rp2;
      rv3 <= rv2;

      row_x.s   <= xx[0] + xx[1] + xx[2];
      row_x.t   <= xx;
      row_x.neg <= nx3;
      row_p     <= rp3;
      row_v     <= rv3;
    end
  end

  assign out_vld = vld[3];

endmodule

### design/ofbm_lane.sv
module ofbm_lane (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  ofbm_pkg::row_t   row,
  output logic             out_vld,
  output logic [2:0][15:0] ent,
  output logic             zero
);

  localparam int Steps = ofbm_pkg::STEPS;

  typedef struct packed {
    logic [63:0]                         s;
    logic                                z;
    logic [2:0]                          neg;
    logic [2:0][ofbm_pkg::R_W-1:0]       r;
    logic [2:0][ofbm_pkg::P_W-1:0]       p;
    logic [2:0][ofbm_pkg::Q_W-1:0]       q;
  } lane_st_t;

  lane_st_t   st [Steps+1];
  logic [Steps:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Steps-1:0], in_vld};
    end
  end

  // load remainder with t * 2^28
  always_ff @(posedge clk) begin
    if (en) begin
      st[0].s   <= row.s;
      st[0].z   <= (row.s == 64'd0);
      st[0].neg <= row.neg;
      for (int e = 0; e < 3; e++) begin
        st[0].r[e] <= ofbm_pkg::R_W'({row.t[e], 28'd0});
        st[0].p[e] <= '0;
        st[0].q[e] <= '0;
      end
    end
  end

  // one quotient bit per stage: try q + 2^b against the remainder
  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int B = Steps - 1 - k;
    lane_st_t nxt;
    logic [ofbm_pkg::R_W-1:0] d [3];

    always_comb begin
      nxt = st[k];
      for (int e = 0; e < 3; e++) begin
        d[e] = (ofbm_pkg::R_W'(st[k].p[e]) << (B + 1))
             + (ofbm_pkg::R_W'(st[k].s) << (2 * B));
        if (d[e] <= st[k].r[e]) begin
          nxt.r[e]    = st[k].r[e] - d[e];
          nxt.p[e]    = st[k].p[e] + (ofbm_pkg::P_W'(st[k].s) << B);
          nxt.q[e][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      if (st[Steps].z) begin
        ent[e] = '0;
      end else if (st[Steps].neg[e]) begin
        ent[e] = -{1'b0, st[Steps].q[e]};
      end else begin
        ent[e] = {1'b0, st[Steps].q[e]};
      end
    end
  end

  assign zero    = st[Steps].z;
  assign out_vld = vld[Steps];

endmodule

### design/orbit_frame_basis_matrix.sv
// Orbital frame basis matrix.
//
// state_vec carries one word of position and velocity (16-bit signed
// components); frame returns one word per input: the unit position row,
// the unit velocity row and the unit position-cross-velocity row, each
// entry truncated toward zero in signed Q1.14, plus a mask of rows whose
// vector was all zero (those rows read as zeros).
//
// Structure: 21 register stages. Four front stages form squares, cross
// product and sums of squares; a load stage and fifteen stages then
// resolve one quotient bit each for all nine entries by shift-and-subtract
// against an exact integer remainder; one output register follows.
// Throughput: one word per cycle while state_vec.ready is high.
//
// Reset clears every valid bit; no words are in flight afterward.
// When frame stalls, the output register holds its word and a skid
// register takes one more; only then does state_vec.ready drop and the
// whole pipeline freeze, so nothing is lost or repeated.
module orbit_frame_basis_matrix (
  input  logic              clk,
  input  logic              rst,
  ofbm_in_if.sink           state_vec,
  ofbm_out_if.source        frame
);

  logic                en;
  logic                front_vld;
  ofbm_pkg::row_t      row_p, row_v, row_x;
  logic [2:0]          lane_vld;
  logic [2:0][15:0]    ent_p, ent_v, ent_x;
  logic [2:0]          zero;
  logic                push;
  ofbm_pkg::out_word_t pd;

  logic                ov, sv;
  ofbm_pkg::out_word_t od, sd;

  // freeze the pipeline only while the skid register is occupied
  assign en              = ~sv;
  assign state_vec.ready = en;

  ofbm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (state_vec.valid),
    .word    (state_vec.data),
    .out_vld (front_vld),
    .row_p   (row_p),
    .row_v   (row_v),
    .row_x   (row_x)
  );

  ofbm_lane u_lane_p (
    .clk (clk), .rst (rst), .en (en), .in_vld (front_vld), .row (row_p),
    .out_vld (lane_vld[0]), .ent (ent_p), .zero (zero[0])
  );

  ofbm_lane u_lane_v (
    .clk (clk), .rst (rst), .en (en), .in_vld (front_vld), .row (row_v),
    .out_vld (lane_vld[1]), .ent (ent_v), .zero (zero[1])
  );

  ofbm_lane u_lane_x (
    .clk (clk), .rst (rst), .en (en), .in_vld (front_vld), .row (row_x),
    .out_vld (lane_vld[2]), .ent (ent_x), .zero (zero[2])
  );

  // assemble the result word from the three lanes
  always_comb begin
    pd.m00             = ent_p[0];
    pd.m01             = ent_p[1];
    pd.m02             = ent_p[2];
    pd.m10             = ent_v[0];
    pd.m11             = ent_v[1];
    pd.m12             = ent_v[2];
    pd.m20             = ent_x[0];
    pd.m21             = ent_x[1];
    pd.m22             = ent_x[2];
    pd.degenerate_rows = zero;
  end

  assign push = lane_vld[0] & en;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (ov && !frame.ready) begin
      if (push) begin
        sv <= 1'b1;
      end
    end else if (sv) begin
      ov <= 1'b1;
      sv <= 1'b0;
    end else begin
      ov <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (ov && !frame.ready) begin
      if (push) begin
        sd <= pd;
      end
    end else if (sv) begin
      od <= sd;
    end else if (push) begin
      od <= pd;
    end
  end

  assign frame.valid = ov;
  assign frame.data  = od;

  // the three lanes advance in lockstep
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    lane_vld[0] == lane_vld[1] && lane_vld[0] == lane_vld[2])
    else $error("lane valid bits diverged");

  // the skid entry is only filled behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sv |-> ov)
    else $error("skid occupied with empty output register");

  // a zero position row reads as zeros
  a_zero_row_p: assert property (@(posedge clk) disable iff (rst)
    ov && od.degenerate_rows[0] |->
      od.m00 == 16'sd0 && od.m01 == 16'sd0 && od.m02 == 16'sd0)
    else $error("degenerate position row not zero");

  // a zero position or velocity forces a zero cross product
  a_zero_cross: assert property (@(posedge clk) disable iff (rst)
    ov && (od.degenerate_rows[0] || od.degenerate_rows[1]) |->
      od.degenerate_rows[2])
    else $error("cross row not flagged for zero input vector");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int LATENCY     = 20;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;

  ofbm_in_if  state_vec ();
  ofbm_out_if frame ();

  orbit_frame_basis_matrix u_dut (
    .clk       (clk),
    .rst       (rst),
    .state_vec (state_vec.sink),
    .frame     (frame.source)
  );

  ofbm_pkg::in_word_t  pending_vecs[$];
  ofbm_pkg::out_word_t expected_frames[$];
  int        errors;
  int        cycle_count;
  bit        stim_done;
  bit        hold_off;
  bit        hold_done;
  bit        calm_send;
  bit        calm_recv;

  // Unit component of one entry: largest q with sum * q^2 <= c^2 * 2^28,
  // found one bit at a time from the top, then signed like the component.
  function automatic logic signed [15:0] unit_entry(longint signed comp,
                                                     logic [127:0] sumsq);
    logic [127:0] mag_sq;
    logic [14:0]  q;
    logic [14:0]  trial;
    longint       a;
    a      = comp < 0 ? -comp : comp;
    mag_sq = (128'(a) * 128'(a)) << 28;
    q      = '0;
    for (int b = 14; b >= 0; b--) begin
      trial = q | (15'd1 << b);
      if (sumsq * 128'(trial) * 128'(trial) <= mag_sq) q = trial;
    end
    return comp < 0 ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  // Normalize a 3-vector into three Q1.14 entries; report a zero vector.
  function automatic bit unit_row(input longint signed c[3],
                                  output logic signed [15:0] r[3]);
    logic [127:0] sumsq;
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      sumsq += 128'((c[i] < 0 ? -c[i] : c[i])) * 128'((c[i] < 0 ? -c[i] : c[i]));
    end
    for (int i = 0; i < 3; i++) r[i] = (sumsq == 0) ? '0 : unit_entry(c[i], sumsq);
    return sumsq == 0;
  endfunction

  function automatic ofbm_pkg::out_word_t frame_of(ofbm_pkg::in_word_t w);
    longint signed        p[3];
    longint signed        v[3];
    longint signed        x[3];
    logic signed [15:0]   r[3];
    ofbm_pkg::out_word_t  f;
    p = '{longint'(w.pos_x), longint'(w.pos_y), longint'(w.pos_z)};
    v = '{longint'(w.vel_x), longint'(w.vel_y), longint'(w.vel_z)};
    x[0] = p[1] * v[2] - p[2] * v[1];
    x[1] = p[2] * v[0] - p[0] * v[2];
    x[2] = p[0] * v[1] - p[1] * v[0];
    f.degenerate_rows[0] = unit_row(p, r);
    f.m00 = r[0]; f.m01 = r[1]; f.m02 = r[2];
    f.degenerate_rows[1] = unit_row(v, r);
    f.m10 = r[0]; f.m11 = r[1]; f.m12 = r[2];
    f.degenerate_rows[2] = unit_row(x, r);
    f.m20 = r[0]; f.m21 = r[1]; f.m22 = r[2];
    return f;
  endfunction

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3:       return $signed(16'($urandom_range(0, 15)) - 16'd8);
      default: return $signed(16'($urandom));
    endcase
  endfunction

  task automatic push_vec(logic signed [15:0] px, py, pz, vx, vy, vz);
    ofbm_pkg::in_word_t w;
    w = '{px, py, pz, vx, vy, vz};
    pending_vecs.push_back(w);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold reset from time zero, then release it on a falling edge.
  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Fill the stimulus queue: directed corners first, then random vectors.
  initial begin
    ofbm_pkg::in_word_t w;
    logic signed [15:0] k;
    stim_done = 1'b0;
    // all zero: every row degenerate
    push_vec(0, 0, 0, 0, 0, 0);
    // single nonzero component gives exactly +-16384
    push_vec(16'sh7fff, 0, 0, 0, 16'sh8000, 0);
    push_vec(0, 16'sh8000, 0, 0, 0, 16'sh7fff);
    push_vec(0, 0, -1, 1, 0, 0);
    // position zero, velocity nonzero; and the reverse
    push_vec(0, 0, 0, 3, -4, 12);
    push_vec(5, 7, -9, 0, 0, 0);
    // parallel and antiparallel: cross row zero
    push_vec(100, -200, 300, -300, 600, -900);
    push_vec(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    push_vec(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
    // extremes and mixed corners: full-scale, small and patterned components
    push_vec(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    push_vec(16'sh8000, 0, 0, 0, 16'sh8000, 0);
    push_vec(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    push_vec(-1, -1, -1, 1, -1, 1);
    push_vec(1, 1, 1, 1, 1, 1);
    push_vec(3, 4, 0, 0, 0, 5);
    push_vec(16'sh5555, 16'shaaaa, 16'sh0f0f, 16'shf0f0, 16'sh3333, 16'shcccc);
    push_vec(16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000, 16'sh0000, 16'shc000);
    for (int n = 0; n < 1030; n++) begin
      if (n % 20 == 0) begin
        // parallel pair with random scale, so the cross row degenerates
        k = $signed(16'($urandom_range(0, 6))) - 16'sd3;
        w.pos_x = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
        w.pos_y = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
        w.pos_z = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
        w.vel_x = w.pos_x * k;
        w.vel_y = w.pos_y * k;
        w.vel_z = w.pos_z * k;
      end else begin
        w = '{rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
              rand_comp()};
      end
      pending_vecs.push_back(w);
    end
    stim_done = 1'b1;
  end

  // Record each accepted word and drop it from the queue.
  always @(posedge clk) begin
    if (!rst && state_vec.valid && state_vec.ready) begin
      expected_frames.push_back(frame_of(state_vec.data));
      void'(pending_vecs.pop_front());
    end
  end

  // Drive on the falling edge from the head of the queue.
  always @(negedge clk) begin
    if (rst) begin
      state_vec.valid <= 1'b0;
      state_vec.data  <= '0;
      hold_off        <= 1'b0;
      hold_done       <= 1'b0;
    end else begin
      // once, mid-run: stall the sender until the pipe drains
      if (!hold_done && pending_vecs.size() <= 500) begin
        hold_off  <= 1'b1;
        hold_done <= 1'b1;
      end
      if (hold_off && expected_frames.size() == 0) begin
        hold_off <= 1'b0;
      end
      if (pending_vecs.size() != 0 && !(hold_off && expected_frames.size() != 0) &&
          (calm_send || $urandom_range(0, 99) >= 29)) begin
        state_vec.valid <= 1'b1;
        state_vec.data  <= pending_vecs[0];
      end else begin
        state_vec.valid <= 1'b0;
      end
    end
  end

  // Idle both channels until the first falling edge.
  initial begin
    state_vec.valid = 1'b0;
    state_vec.data  = '0;
    frame.ready     = 1'b0;
  end

  always @(negedge clk) begin
    calm_send <= (cycle_count % 4000) < 600;
    calm_recv <= (cycle_count % 4000) < 600;
    frame.ready <= rst ? 1'b0 : (calm_recv || $urandom_range(0, 99) >= 29);
  end

  // Compare each accepted frame with the oldest expectation.
  always @(posedge clk) begin
    ofbm_pkg::out_word_t e;
    ofbm_pkg::out_word_t a;
    if (!rst && frame.valid && frame.ready) begin
      a = frame.data;
      if (expected_frames.size() == 0) begin
        $error("frame with no expectation: %p", a);
        errors++;
      end else begin
        e = expected_frames.pop_front();
        if (a.m00 !== e.m00) begin $error("m00 exp %0d got %0d", e.m00, a.m00); errors++; end
        if (a.m01 !== e.m01) begin $error("m01 exp %0d got %0d", e.m01, a.m01); errors++; end
        if (a.m02 !== e.m02) begin $error("m02 exp %0d got %0d", e.m02, a.m02); errors++; end
        if (a.m10 !== e.m10) begin $error("m10 exp %0d got %0d", e.m10, a.m10); errors++; end
        if (a.m11 !== e.m11) begin $error("m11 exp %0d got %0d", e.m11, a.m11); errors++; end
        if (a.m12 !== e.m12) begin $error("m12 exp %0d got %0d", e.m12, a.m12); errors++; end
        if (a.m20 !== e.m20) begin $error("m20 exp %0d got %0d", e.m20, a.m20); errors++; end
        if (a.m21 !== e.m21) begin $error("m21 exp %0d got %0d", e.m21, a.m21); errors++; end
        if (a.m22 !== e.m22) begin $error("m22 exp %0d got %0d", e.m22, a.m22); errors++; end
        if (a.degenerate_rows !== e.degenerate_rows) begin
          $error("degenerate_rows exp %0d got %0d", e.degenerate_rows, a.degenerate_rows);
          errors++;
        end
      end
    end
  end

  // Count cycles; end the run on drain or on the cycle limit.
  initial begin
    errors      = 0;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (stim_done && !rst && pending_vecs.size() == 0 && expected_frames.size() == 0 &&
          !state_vec.valid) begin
        repeat (LATENCY * 3) @(posedge clk);
        if (errors == 0 && expected_frames.size() == 0) begin
          $display("Testbench completed without errors");
        end else begin
          $display("Testbench completed WITH ERRORS");
        end
        $finish;
      end
    end
  end

endmodule
